// File: sv/sha1_pkg.sv
// sha1_pkg: shared types, constants and round functions for the sha-1 hasher
// depends on nothing
`default_nettype none
package sha1_pkg;
	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;
	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = 2;

	// one classified byte for the back end
	typedef struct packed {
		logic [7:0] data;
		logic       last; // final padding byte of the message
	} byte_cmd_t;

	typedef enum logic [1:0] {
		FE_IDLE,
		FE_PAD,
		FE_LEN
	} fe_state_t;

	typedef enum logic [1:0] {
		BE_FILL,
		BE_ROUND,
		BE_FINISH,
		BE_OUT
	} be_state_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
		rotl = (v << n) | (v >> (32 - n));
	endfunction

	function automatic logic [31:0] round_f(input logic [6:0] r,
			input logic [31:0] b, input logic [31:0] c, input logic [31:0] d);
		if (r < 7'd20)      round_f = (b & c) | (~b & d);
		else if (r < 7'd40) round_f = b ^ c ^ d;
		else if (r < 7'd60) round_f = (b & c) | (b & d) | (c & d);
		else                round_f = b ^ c ^ d;
	endfunction

	function automatic logic [31:0] round_k(input logic [6:0] r);
		if (r < 7'd20)      round_k = K0;
		else if (r < 7'd40) round_k = K1;
		else if (r < 7'd60) round_k = K2;
		else                round_k = K3;
	endfunction
endpackage
`default_nettype wire

// File: sv/sha1_if.sv
// sha1_if: valid/ready channels for input bytes and for digest words
// depends on nothing
`default_nettype none
interface sha1_in_if (input wire logic clk);
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       end_of_message;
	modport source (output valid, data_byte, has_byte, end_of_message, input ready);
	modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha1_out_if (input wire logic clk);
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// File: sv/sha1_front.sv
// sha1_front: accepts input items, counts bytes and generates padding bytes
// depends on sha1_pkg, sha1_if
`default_nettype none
module sha1_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	sha1_in_if.sink              in_ch,
	output sha1_pkg::byte_cmd_t  cmd,
	output logic                 cmd_valid,
	input  wire logic            cmd_ready
);
	sha1_pkg::fe_state_t state_q, state_d;
	logic [60:0] count_q;
	logic [63:0] bits_q;
	logic [2:0]  len_idx_q;
	logic        pend_end_q;
	logic        push;
	logic        accept;

	// input byte and the 0x80 pad byte go out in idle; zero and length padding follow in their own states
	assign in_ch.ready = (state_q == sha1_pkg::FE_IDLE) && !pend_end_q && cmd_ready;
	assign accept = in_ch.valid && in_ch.ready;

	// output selection
	always_comb begin
		cmd_valid = 1'b0;
		cmd.data = 8'h00;
		cmd.last = 1'b0;
		unique case (state_q)
			sha1_pkg::FE_IDLE: begin
				if (pend_end_q) begin
					cmd_valid = 1'b1;
					cmd.data = sha1_pkg::PAD_BYTE;
				end else begin
					cmd_valid = in_ch.valid && in_ch.has_byte;
					cmd.data = in_ch.data_byte;
				end
			end
			sha1_pkg::FE_PAD: begin
				cmd_valid = 1'b1;
			end
			sha1_pkg::FE_LEN: begin
				cmd_valid = 1'b1;
				cmd.data = bits_q[63 - 8*len_idx_q -: 8];
				cmd.last = (len_idx_q == 3'd7);
			end
			default: ;
		endcase
	end

	assign push = cmd_valid && cmd_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sha1_pkg::FE_IDLE:
				if (pend_end_q && push)
					state_d = (count_q[5:0] + 6'd1 == sha1_pkg::LEN_POS) ?
						sha1_pkg::FE_LEN : sha1_pkg::FE_PAD;
			sha1_pkg::FE_PAD:
				if (push && count_q[5:0] + 6'd1 == sha1_pkg::LEN_POS)
					state_d = sha1_pkg::FE_LEN;
			sha1_pkg::FE_LEN:
				if (push && len_idx_q == 3'd7) state_d = sha1_pkg::FE_IDLE;
			default: state_d = sha1_pkg::FE_IDLE;
		endcase
	end

	// counters and end latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha1_pkg::FE_IDLE;
			count_q <= '0;
			len_idx_q <= '0;
			pend_end_q <= 1'b0;
			bits_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (in_ch.has_byte) count_q <= count_q + 61'd1;
				if (in_ch.end_of_message) begin
					pend_end_q <= 1'b1;
					bits_q <= {(in_ch.has_byte ? count_q + 61'd1 : count_q), 3'b000};
				end
			end else if (push) begin
				count_q <= count_q + 61'd1;
				if (state_q == sha1_pkg::FE_IDLE) pend_end_q <= 1'b0;
				if (state_q == sha1_pkg::FE_LEN) begin
					len_idx_q <= len_idx_q + 3'd1;
					if (len_idx_q == 3'd7) count_q <= '0;
				end
			end
		end
	end
endmodule
`default_nettype wire

// File: sv/sha1_queue.sv
// sha1_queue: small fifo of byte commands between front and back end
// depends on sha1_pkg
`default_nettype none
module sha1_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  sha1_pkg::byte_cmd_t wr_data,
	input  wire logic           wr_valid,
	output logic                wr_ready,
	output sha1_pkg::byte_cmd_t rd_data,
	output logic                rd_valid,
	input  wire logic           rd_ready
);
	sha1_pkg::byte_cmd_t mem_q [sha1_pkg::QUEUE_DEPTH];
	logic [sha1_pkg::QUEUE_AW-1:0] wp_q, rp_q;
	logic [sha1_pkg::QUEUE_AW:0]   cnt_q;
	logic wr, rd;

	assign wr_ready = (cnt_q != (sha1_pkg::QUEUE_AW+1)'(sha1_pkg::QUEUE_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	// storage
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (sha1_pkg::QUEUE_AW+1)'(wr) - (sha1_pkg::QUEUE_AW+1)'(rd);
		end
	end
endmodule
`default_nettype wire

// File: sv/sha1_back.sv
// sha1_back: packs bytes into the block buffer, runs 80 rounds, emits digest
// depends on sha1_pkg, sha1_if
`default_nettype none
module sha1_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  sha1_pkg::byte_cmd_t cmd,
	input  wire logic           cmd_valid,
	output logic                cmd_ready,
	sha1_out_if.source          out_ch
);
	sha1_pkg::be_state_t state_q, state_d;
	logic [31:0] w_q [16];
	logic [31:0] h_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [5:0]  pos_q;
	logic [6:0]  rnd_q;
	logic        last_q;
	logic [2:0]  oidx_q;
	logic [31:0] w_new, w_cur, t_val;
	logic [3:0]  s;
	logic        take;

	assign cmd_ready = (state_q == sha1_pkg::BE_FILL);
	assign take = cmd_valid && cmd_ready;

	// schedule word and round sum
	assign s = rnd_q[3:0];
	assign w_new = sha1_pkg::rotl(w_q[s + 4'd13] ^ w_q[s + 4'd8] ^ w_q[s + 4'd2] ^ w_q[s], 1);
	assign w_cur = (rnd_q < 7'd16) ? w_q[s] : w_new;
	assign t_val = sha1_pkg::rotl(a_q, 5) + sha1_pkg::round_f(rnd_q, b_q, c_q, d_q)
		+ e_q + sha1_pkg::round_k(rnd_q) + w_cur;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sha1_pkg::BE_FILL:   if (take && pos_q == 6'd63) state_d = sha1_pkg::BE_ROUND;
			sha1_pkg::BE_ROUND:  if (rnd_q == 7'd79) state_d = sha1_pkg::BE_FINISH;
			sha1_pkg::BE_FINISH: state_d = last_q ? sha1_pkg::BE_OUT : sha1_pkg::BE_FILL;
			sha1_pkg::BE_OUT:
				if (out_ch.ready && oidx_q == 3'd4) state_d = sha1_pkg::BE_FILL;
			default: state_d = sha1_pkg::BE_FILL;
		endcase
	end

	// outputs
	always_comb begin
		out_ch.valid = (state_q == sha1_pkg::BE_OUT);
		out_ch.digest_word = h_q[oidx_q];
		out_ch.word_index = oidx_q;
		out_ch.last_word = (oidx_q == 3'd4);
	end

	// buffer and working registers
	always_ff @(posedge clk) begin
		if (take)
			w_q[pos_q[5:2]][31 - 8*pos_q[1:0] -: 8] <= cmd.data;
		if (state_q == sha1_pkg::BE_ROUND) begin
			w_q[s] <= w_cur;
			e_q <= d_q;
			d_q <= c_q;
			c_q <= sha1_pkg::rotl(b_q, 30);
			b_q <= a_q;
			a_q <= t_val;
		end else begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end
	end

	// control and chaining state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha1_pkg::BE_FILL;
			pos_q <= '0;
			rnd_q <= '0;
			last_q <= 1'b0;
			oidx_q <= '0;
			h_q[0] <= sha1_pkg::H0;
			h_q[1] <= sha1_pkg::H1;
			h_q[2] <= sha1_pkg::H2;
			h_q[3] <= sha1_pkg::H3;
			h_q[4] <= sha1_pkg::H4;
		end else begin
			state_q <= state_d;
			if (take) begin
				pos_q <= pos_q + 6'd1;
				last_q <= cmd.last;
			end
			if (state_q == sha1_pkg::BE_ROUND)
				rnd_q <= (rnd_q == 7'd79) ? 7'd0 : rnd_q + 7'd1;
			if (state_q == sha1_pkg::BE_FINISH) begin
				h_q[0] <= h_q[0] + a_q;
				h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q;
				h_q[3] <= h_q[3] + d_q;
				h_q[4] <= h_q[4] + e_q;
			end
			if (state_q == sha1_pkg::BE_OUT && out_ch.ready) begin
				oidx_q <= oidx_q + 3'd1;
				if (oidx_q == 3'd4) begin
					oidx_q <= '0;
					last_q <= 1'b0;
					h_q[0] <= sha1_pkg::H0;
					h_q[1] <= sha1_pkg::H1;
					h_q[2] <= sha1_pkg::H2;
					h_q[3] <= sha1_pkg::H3;
					h_q[4] <= sha1_pkg::H4;
				end
			end
		end
	end
endmodule
`default_nettype wire

// File: sv/sha1_message_hasher.sv
// sha1_message_hasher: byte-serial sha-1, one byte per cycle into the buffer while the
// back end is filling, then 80 rounds plus one chaining step per 64-byte block; the
// sustained byte rate is set by the round loop
// digest: five words, the first offered after the chaining step of the final block
// reset: asynchronous, restores initial chaining values and clears all counters
`default_nettype none
module sha1_message_hasher (
	input  wire logic clk,
	input  wire logic arst_n,
	sha1_in_if.sink   in_ch,
	sha1_out_if.source out_ch
);
	sha1_pkg::byte_cmd_t f_cmd, b_cmd;
	logic f_valid, f_ready, b_valid, b_ready;

	sha1_front u_front (.clk, .arst_n, .in_ch, .cmd(f_cmd), .cmd_valid(f_valid),
		.cmd_ready(f_ready));
	sha1_queue u_queue (.clk, .arst_n, .wr_data(f_cmd), .wr_valid(f_valid),
		.wr_ready(f_ready), .rd_data(b_cmd), .rd_valid(b_valid), .rd_ready(b_ready));
	sha1_back u_back (.clk, .arst_n, .cmd(b_cmd), .cmd_valid(b_valid),
		.cmd_ready(b_ready), .out_ch);

	// digest words leave in index order ending on the last-word flag
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.last_word == (out_ch.word_index == 3'd4)))
		else $error("last_word mismatch");
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.word_index <= 3'd4))
		else $error("word index out of range");
	// no byte reaches the back end while it emits the digest
	a_nofill: assert property (@(posedge clk) disable iff (!arst_n)
		(b_valid && b_ready) |-> !out_ch.valid)
		else $error("byte taken during output");
endmodule
`default_nettype wire

// File: dv/sha1_message_hasher_tb.sv
// sha1_message_hasher_tb: self-checking bench for the byte-serial sha-1 hasher
// drives message bytes over the input channel and checks digest transactions
// depends on sha1_pkg, sha1_if and sha1_message_hasher
`default_nettype none
module sha1_message_hasher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1500000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sha1_in_if in_ch (clk);
	sha1_out_if out_ch (clk);

	sha1_message_hasher uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_txn_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
		logic       known;        // expected first word typed in
		logic [31:0] first_word;
	} stim_row_t;

	// predictor state
	logic [31:0] chain_h [5];
	logic [31:0] msg_words [16];
	logic [60:0] msg_bytes;

	digest_txn_t pending_digest[$];
	int errors = 0;
	int words_seen = 0;
	int msgs_sent = 0;
	int cycles = 0;
	int send_idle_pct = 9;
	int recv_idle_pct = 45;
	bit hold_off = 1'b0;

	function automatic logic [31:0] rol(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	task automatic chain_reset();
		chain_h[0] = sha1_pkg::H0; chain_h[1] = sha1_pkg::H1; chain_h[2] = sha1_pkg::H2;
		chain_h[3] = sha1_pkg::H3; chain_h[4] = sha1_pkg::H4;
		for (int i = 0; i < 16; i++) msg_words[i] = '0;
		msg_bytes = '0;
	endtask

	task automatic compress_block();
		logic [31:0] a, b, c, d, e, f, k, w, t;
		int s;
		a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
		for (int r = 0; r < 80; r++) begin
			s = r & 15;
			if (r >= 16)
				msg_words[s] = rol(msg_words[(s + 13) & 15] ^ msg_words[(s + 8) & 15]
					^ msg_words[(s + 2) & 15] ^ msg_words[s], 1);
			w = msg_words[s];
			if (r < 20) begin
				f = (b & c) | (~b & d); k = sha1_pkg::K0;
			end else if (r < 40) begin
				f = b ^ c ^ d; k = sha1_pkg::K1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d); k = sha1_pkg::K2;
			end else begin
				f = b ^ c ^ d; k = sha1_pkg::K3;
			end
			t = rol(a, 5) + f + e + k + w;
			e = d; d = c; c = rol(b, 30); b = a; a = t;
		end
		chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d; chain_h[4] += e;
	endtask

	task automatic absorb_byte(input logic [7:0] bt);
		int pos;
		pos = msg_bytes[5:0];
		msg_words[pos >> 2][(3 - (pos & 3)) * 8 +: 8] = bt;
		msg_bytes = msg_bytes + 1'b1;
		if (pos == 63) compress_block();
	endtask

	// predict digest words for one accepted transaction
	task automatic predict_digest(input logic [7:0] bt, input logic has, input logic eom);
		logic [63:0] bit_len;
		digest_txn_t dw;
		if (has) absorb_byte(bt);
		if (eom) begin
			bit_len = {msg_bytes, 3'b000};
			absorb_byte(sha1_pkg::PAD_BYTE);
			while (msg_bytes[5:0] != sha1_pkg::LEN_POS) absorb_byte(8'h00);
			for (int i = 0; i < 8; i++) absorb_byte(bit_len[(7 - i) * 8 +: 8]);
			for (int i = 0; i < 5; i++) begin
				dw.digest_word = chain_h[i];
				dw.word_index = 3'(i);
				dw.last_word = (i == 4);
				pending_digest.push_back(dw);
			end
			chain_reset();
		end
	endtask

	// send one transaction, with random sender idling
	task automatic send_byte(input logic [7:0] bt, input logic has, input logic eom);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= bt;
		in_ch.has_byte <= has;
		in_ch.end_of_message <= eom;
		do @(posedge clk); while (!in_ch.ready);
		predict_digest(bt, has, eom);
		if (eom) msgs_sent++;
		@(negedge clk);
	endtask

	task automatic send_message(input int len);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom), 1'b1, (i == len - 1) && $urandom_range(1));
		if (len == 0 || !(in_ch.end_of_message && in_ch.has_byte))
			send_byte(8'($urandom), 1'b0, 1'b1);
	endtask

	// directed rows: empty message and "abc" have well-known digests
	stim_row_t dir_rows [] = '{
		'{8'h00, 1'b0, 1'b1, 1'b1, 32'hDA39A3EE},
		'{8'hFF, 1'b0, 1'b0, 1'b0, 32'h0},
		'{8'h61, 1'b1, 1'b0, 1'b0, 32'h0},
		'{8'h62, 1'b1, 1'b0, 1'b0, 32'h0},
		'{8'h63, 1'b1, 1'b1, 1'b1, 32'hA9993E36},
		'{8'h00, 1'b1, 1'b1, 1'b0, 32'h0},
		'{8'hFF, 1'b1, 1'b1, 1'b0, 32'h0},
		'{8'hAA, 1'b1, 1'b0, 1'b0, 32'h0},
		'{8'h55, 1'b1, 1'b0, 1'b0, 32'h0},
		'{8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
		'{8'h80, 1'b0, 1'b1, 1'b0, 32'h0}
	};

	// receiver: random stalls, checking against oldest expectation
	always @(negedge clk) begin
		out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		digest_txn_t got, exp;
		cycles <= cycles + 1;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.digest_word = out_ch.digest_word;
			got.word_index = out_ch.word_index;
			got.last_word = out_ch.last_word;
			words_seen <= words_seen + 1;
			if (pending_digest.size() == 0) begin
				$display("%0t: unexpected digest transaction %h/%0d/%0b", $realtime,
					got.digest_word, got.word_index, got.last_word);
				errors <= errors + 1;
			end else begin
				exp = pending_digest.pop_front();
				if (got !== exp) begin
					$display("%0t: digest mismatch expected %h/%0d/%0b actual %h/%0d/%0b",
						$realtime, exp.digest_word, exp.word_index, exp.last_word,
						got.digest_word, got.word_index, got.last_word);
					errors <= errors + 1;
				end
			end
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("sha1_message_hasher test failed");
			$finish;
		end
	end

	// long receiver hold-off while the sender keeps offering
	initial begin
		int n;
		wait (msgs_sent >= 8);
		@(negedge clk);
		hold_off = 1'b1;
		for (n = 0; n < 600; n++) @(negedge clk);
		hold_off = 1'b0;
	end

	// main stimulus
	initial begin
		int len;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.has_byte = 1'b0;
		in_ch.end_of_message = 1'b0;
		out_ch.ready = 1'b0;
		chain_reset();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		foreach (dir_rows[i]) begin
			send_byte(dir_rows[i].data_byte, dir_rows[i].has_byte,
				dir_rows[i].end_of_message);
			if (dir_rows[i].known && pending_digest.size() >= 5
					&& pending_digest[pending_digest.size() - 5].digest_word
					!== dir_rows[i].first_word) begin
				$display("%0t: known digest expected %h actual %h", $realtime,
					dir_rows[i].first_word,
					pending_digest[pending_digest.size() - 5].digest_word);
				errors++;
			end
		end

		// random messages in three idling phases, lengths mostly around block edges
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 45 : 0;
			recv_idle_pct = (ph == 0) ? 45 : (ph == 1) ? 9 : 0;
			for (int m = 0; m < 2; m++) begin
				case ($urandom_range(3))
					0: len = $urandom_range(0, 8);
					1: len = $urandom_range(54, 66);
					2: len = $urandom_range(118, 130);
					default: len = $urandom_range(9, 53);
				endcase
				if ($urandom_range(9) == 0) send_byte(8'($urandom), 1'b0, 1'b0);
				send_message(len);
			end
		end
		in_ch.valid <= 1'b0;

		// drain
		while (pending_digest.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		$display("ran %0d messages, including empty, abc and block-boundary lengths,",
			msgs_sent);
		$display("checked %0d digest words under sender/receiver stalls", words_seen);
		if (errors == 0)
			$display("sha1_message_hasher test passed");
		else
			$display("sha1_message_hasher test failed");
		$finish;
	end
endmodule
`default_nettype wire
